// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros for the core RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed: condition does not hold");

// When the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: expected response one cycle later");

`else

`define ASSERT_ALWAYS(label, clk, rst, cond)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/core/pedq_pkg.sv =====
// ----------------------------------------------------------------------------
// pedq_pkg
// Types, constants and sizes shared by the pointer event deframer queue.
// ----------------------------------------------------------------------------
package pedq_pkg;

  // Queue depth and the widths that follow from it.
  localparam int QUEUE_DEPTH = 16;
  localparam int ADDR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int CNT_W       = FILL_W + 1;

  // Fixed field widths.
  localparam int TYPE_W     = 3;
  localparam int BYTE_W     = 8;
  localparam int COORD_W    = 16;
  localparam int EV_COUNT_W = 5;
  localparam int POS_W      = 3;
  localparam int TOUCH_W    = 9;

  // Event type codes.
  localparam logic [TYPE_W-1:0] EV_TOUCH_START  = 3'd0;
  localparam logic [TYPE_W-1:0] EV_TOUCH_MOVE   = 3'd1;
  localparam logic [TYPE_W-1:0] EV_TOUCH_CANCEL = 3'd2;
  localparam logic [TYPE_W-1:0] EV_TOUCH_END    = 3'd3;
  localparam logic [TYPE_W-1:0] EV_MOUSE_DOWN   = 3'd4;
  localparam logic [TYPE_W-1:0] EV_MOUSE_MOVE   = 3'd5;
  localparam logic [TYPE_W-1:0] EV_MOUSE_UP     = 3'd6;
  localparam logic [TYPE_W-1:0] EV_HOVER_MOVE   = 3'd7;

  // Tracked touch value that matches no identifier.
  localparam logic [TOUCH_W-1:0] NO_TOUCH = 9'd256;

  // Frame byte positions.
  localparam logic [POS_W-1:0] POS_TYPE   = 3'd0;
  localparam logic [POS_W-1:0] POS_IDENT  = 3'd1;
  localparam logic [POS_W-1:0] POS_X_LOW  = 3'd2;
  localparam logic [POS_W-1:0] POS_X_HIGH = 3'd3;
  localparam logic [POS_W-1:0] POS_Y_LOW  = 3'd4;

  // One queued event.
  typedef struct packed {
    logic [TYPE_W-1:0]  ev_type;
    logic [BYTE_W-1:0]  ident;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } event_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic byte_take;
    logic drain_start;
    logic rd_issue;
    logic out_load;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
    logic drain_last;
  } ctrl_stat_t;

endpackage

// ===== rtl/core/pedq_ctrl.sv =====
// ----------------------------------------------------------------------------
// pedq_ctrl
// Sequencer that takes input items and steps a drain run event by event.
// ----------------------------------------------------------------------------
module pedq_ctrl import pedq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       op,
  input  ctrl_stat_t stat,
  output ctrl_cmd_t  cmd,
  output logic       in_stall
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_EMIT
  } state_t;

  state_t state;
  state_t state_next;

  // Command decode and next state.
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (op) begin
            cmd.drain_start = 1'b1;
            state_next      = ST_FETCH;
          end else begin
            cmd.byte_take = 1'b1;
          end
        end
      end
      ST_FETCH: begin
        cmd.rd_issue = 1'b1;
        state_next   = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = stat.drain_last ? ST_IDLE : ST_FETCH;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // New items are taken only between drain runs.
  assign in_stall = (state != ST_IDLE);

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/core/pedq_datapath.sv =====
// ----------------------------------------------------------------------------
// pedq_datapath
// Frame assembly, pointer status, event memory and the output register.
// ----------------------------------------------------------------------------
module pedq_datapath import pedq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  ctrl_cmd_t             cmd,
  output ctrl_stat_t            stat,
  input  logic [BYTE_W-1:0]     rx_byte,
  input  logic                  out_stall,
  output logic                  out_valid,
  output logic                  ev_valid,
  output logic [TYPE_W-1:0]     ev_type,
  output logic [BYTE_W-1:0]     ev_ident,
  output logic [COORD_W-1:0]    ev_x,
  output logic [COORD_W-1:0]    ev_y,
  output logic [EV_COUNT_W-1:0] event_count,
  output logic                  last,
  output logic [COORD_W-1:0]    pointer_x,
  output logic [COORD_W-1:0]    pointer_y,
  output logic                  dragging
);

  // Frame assembly registers.
  logic [POS_W-1:0]   frame_pos;
  logic [TYPE_W-1:0]  frame_type;
  logic [BYTE_W-1:0]  frame_ident;
  logic [BYTE_W-1:0]  low_byte_hold;
  logic [COORD_W-1:0] frame_x;
  logic [TOUCH_W-1:0] tracked_touch;

  // Pointer status.
  logic [COORD_W-1:0] cur_x;
  logic [COORD_W-1:0] cur_y;
  logic               drag_flag;

  // Event queue.
  event_t             event_store [QUEUE_DEPTH];
  logic [FILL_W-1:0]  queue_fill;
  event_t             rd_data;

  // Drain run bookkeeping.
  logic [FILL_W-1:0]  drain_n;
  logic [ADDR_W-1:0]  drain_idx;
  logic               drain_empty;
  logic               idx_last;

  // Values of the frame that completes with the current byte.
  logic [COORD_W-1:0] fin_y;
  logic               frame_done;
  logic               queue_room;
  logic               touch_match;
  event_t             fin_event;

  assign fin_y       = {rx_byte, low_byte_hold};
  assign frame_done  = cmd.byte_take && (frame_pos > POS_Y_LOW);
  assign queue_room  = (CNT_W'(queue_fill) < CNT_W'(QUEUE_DEPTH));
  assign touch_match = (tracked_touch == {1'b0, frame_ident});
  assign fin_event   = '{ev_type: frame_type, ident: frame_ident, x: frame_x, y: fin_y};

  assign drain_empty = (drain_n == '0);
  assign idx_last    = ((CNT_W'(drain_idx) + CNT_W'(1)) == CNT_W'(drain_n));

  assign stat.out_free   = !out_valid || !out_stall;
  assign stat.drain_last = drain_empty || idx_last;

  // Frame assembly, one byte per accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_pos     <= POS_TYPE;
      frame_type    <= '0;
      frame_ident   <= '0;
      low_byte_hold <= '0;
      frame_x       <= '0;
      tracked_touch <= NO_TOUCH;
    end else if (cmd.byte_take) begin
      case (frame_pos)
        POS_TYPE: begin
          if (rx_byte < BYTE_W'(8)) begin
            frame_type <= rx_byte[TYPE_W-1:0];
            frame_pos  <= POS_IDENT;
          end
        end
        POS_IDENT: begin
          frame_ident <= rx_byte;
          if (frame_type == EV_TOUCH_START) begin
            tracked_touch <= {1'b0, rx_byte};
          end
          frame_pos <= POS_X_LOW;
        end
        POS_X_LOW: begin
          low_byte_hold <= rx_byte;
          frame_pos     <= POS_X_HIGH;
        end
        POS_X_HIGH: begin
          frame_x   <= {rx_byte, low_byte_hold};
          frame_pos <= POS_Y_LOW;
        end
        POS_Y_LOW: begin
          low_byte_hold <= rx_byte;
          frame_pos     <= POS_Y_LOW + POS_W'(1);
        end
        default: begin
          frame_pos <= POS_TYPE;
        end
      endcase
    end
  end

  // Pointer status update when a frame completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x     <= '0;
      cur_y     <= '0;
      drag_flag <= 1'b0;
    end else if (frame_done) begin
      if (frame_type <= EV_TOUCH_END) begin
        if ((frame_type != EV_TOUCH_CANCEL) && touch_match) begin
          cur_x     <= frame_x;
          cur_y     <= fin_y;
          drag_flag <= (frame_type != EV_TOUCH_END);
        end
      end else begin
        cur_x <= frame_x;
        cur_y <= fin_y;
        if (frame_type == EV_MOUSE_DOWN) begin
          drag_flag <= 1'b1;
        end else if (frame_type == EV_MOUSE_UP) begin
          drag_flag <= 1'b0;
        end
      end
    end
  end

  // Fill count and drain run counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      queue_fill <= '0;
      drain_n    <= '0;
      drain_idx  <= '0;
    end else begin
      if (cmd.drain_start) begin
        drain_n    <= queue_fill;
        drain_idx  <= '0;
        queue_fill <= '0;
      end else if (frame_done && queue_room) begin
        queue_fill <= queue_fill + FILL_W'(1);
      end
      if (cmd.out_load && !stat.drain_last) begin
        drain_idx <= drain_idx + ADDR_W'(1);
      end
    end
  end

  // Event memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (frame_done && queue_room) begin
      event_store[queue_fill[ADDR_W-1:0]] <= fin_event;
    end
    if (cmd.rd_issue) begin
      rd_data <= event_store[drain_idx];
    end
  end

  // Output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (drain_empty) begin
        ev_valid <= 1'b0;
        ev_type  <= '0;
        ev_ident <= '0;
        ev_x     <= '0;
        ev_y     <= '0;
        last     <= 1'b1;
      end else begin
        ev_valid <= 1'b1;
        ev_type  <= rd_data.ev_type;
        ev_ident <= rd_data.ident;
        ev_x     <= rd_data.x;
        ev_y     <= rd_data.y;
        last     <= idx_last;
      end
      event_count <= EV_COUNT_W'(drain_n);
      pointer_x   <= cur_x;
      pointer_y   <= cur_y;
      dragging    <= drag_flag;
    end
  end

endmodule

// ===== rtl/core/pointer_event_deframer_queue.sv =====
// ----------------------------------------------------------------------------
// pointer_event_deframer_queue
// Deframes six-byte pointer event frames into a bounded queue and drains it.
// ----------------------------------------------------------------------------
// A byte item is taken and gives no result.
// A drain item runs a fetch state, which reads the event memory into a register,
// then an emit state, which loads the output register when it is free, once per
// event (one result for an empty queue); no new item is taken until it ends.
// Reset is synchronous: it clears the frame, the fill count and the status and
// forgets the tracked touch; the event memory is not cleared.
`include "assert_macros.svh"

module pointer_event_deframer_queue import pedq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  op,
  input  logic [BYTE_W-1:0]     rx_byte,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  ev_valid,
  output logic [TYPE_W-1:0]     ev_type,
  output logic [BYTE_W-1:0]     ev_ident,
  output logic [COORD_W-1:0]    ev_x,
  output logic [COORD_W-1:0]    ev_y,
  output logic [EV_COUNT_W-1:0] event_count,
  output logic                  last,
  output logic [COORD_W-1:0]    pointer_x,
  output logic [COORD_W-1:0]    pointer_y,
  output logic                  dragging
);

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  // Sequencer.
  pedq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .op       (op),
    .stat     (stat),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  // Datapath.
  pedq_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .rx_byte     (rx_byte),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .ev_valid    (ev_valid),
    .ev_type     (ev_type),
    .ev_ident    (ev_ident),
    .ev_x        (ev_x),
    .ev_y        (ev_y),
    .event_count (event_count),
    .last        (last),
    .pointer_x   (pointer_x),
    .pointer_y   (pointer_y),
    .dragging    (dragging)
  );

  // An empty-queue result is always the only and final one of its drain.
  `ASSERT_ALWAYS(a_empty_is_last, clk, rst, !(out_valid && !ev_valid) || last)
  // A result that carries an event reports a nonzero count.
  `ASSERT_ALWAYS(a_event_has_count, clk, rst, !(out_valid && ev_valid) || (event_count != '0))
  // A taken drain item holds off new items while the run is under way.
  `ASSERT_NEXT(a_drain_blocks, clk, rst, in_valid && !in_stall && op, in_stall)
  // After a result that is not the last, the run is still going or its next result waits.
  `ASSERT_NEXT(a_run_continues, clk, rst, out_valid && !out_stall && !last, in_stall || out_valid)

endmodule
